// ----- src/fan_thermostat_controller_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef FAN_THERMOSTAT_CONTROLLER_DEFINES_SVH
`define FAN_THERMOSTAT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define FTC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ftc check failed");

// Next-cycle implication, ignored while reset is asserted.
`define FTC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ftc check failed");

`endif

// ----- src/ftc_pkg.sv -----
package ftc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_FAN_ON   = 2'd1,
    ST_COOLDOWN = 2'd2
  } state_t;

  typedef struct packed {
    logic [31:0] on_limit_ms;
    logic [31:0] cool_len_ms;
  } cfg_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FAN_ON_TIME   = 2'd0;
  localparam logic [1:0] REG_COOLDOWN_TIME = 2'd1;
  localparam logic [1:0] REG_DEFAULT_PCT   = 2'd2;

  localparam logic [31:0] FAN_ON_TIME_RST   = 32'd60000;
  localparam logic [31:0] COOLDOWN_TIME_RST = 32'd30000;
  localparam logic [6:0]  DEFAULT_PCT_RST   = 7'd50;

  localparam logic [7:0]  PCT_MIN = 8'd30;
  localparam logic [7:0]  PCT_MAX = 8'd100;

  // floor(p * 3199 / 100) == (p * CMP_RECIP) >> CMP_SHIFT for all 8-bit p
  localparam logic [21:0] CMP_RECIP = 22'd2096497;
  localparam int          CMP_SHIFT = 16;

endpackage

// ----- src/fan_thermostat_controller.sv -----
// Channel   Dir  Beat contents
// in_       in   tuser: mode; tdata: now_ms, temperature, setpoint, new_percent
// out_      out  tuser: compare_write; tdata: ctrl_state, duty_percent, compare_value
// cfg_      in   APB registers: fan-on limit, cooldown length, default duty
//
// One beat per cycle sustained while out_tready is high. An accepted beat
// passes through the input register, one pass of update logic and the result
// register before it reaches out_. Reset (rst_n low, synchronous) empties both
// registers and returns the controller to idle with duty 50. A stalled out_
// holds its beat while the input register still takes one more beat.
module fan_thermostat_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // now_ms, temperature, setpoint, new_percent
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // ctrl_state, duty_percent, compare_value, pad
  output logic        out_tuser, // compare_write
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ftc_pkg::cfg_t cfg;

  logic               in_valid_r;
  logic               mode_r;
  logic [31:0]        now_r;
  logic signed [15:0] temp_r;
  logic signed [15:0] setp_r;
  logic [7:0]         newp_r;

  logic               out_valid_r;
  logic [1:0]         state_out_r;
  logic [7:0]         duty_out_r;
  logic               cmp_wr_out_r;
  logic [12:0]        cmp_val_out_r;

  logic               advance;
  ftc_pkg::state_t    st_state;
  logic [7:0]         st_duty;
  logic               st_cmp_wr;
  logic [12:0]        st_cmp_val;

  ftc_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  ftc_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (advance),
    .cfg           (cfg),
    .mode          (mode_r),
    .now_ms        (now_r),
    .temperature   (temp_r),
    .setpoint      (setp_r),
    .new_percent   (newp_r),
    .ctrl_state    (st_state),
    .duty_percent  (st_duty),
    .compare_write (st_cmp_wr),
    .compare_value (st_cmp_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_tuser;
      now_r  <= in_tdata[31:0];
      temp_r <= in_tdata[47:32];
      setp_r <= in_tdata[63:48];
      newp_r <= in_tdata[71:64];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_out_r   <= st_state;
      duty_out_r    <= st_duty;
      cmp_wr_out_r  <= st_cmp_wr;
      cmp_val_out_r <= st_cmp_val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = cmp_wr_out_r;
  assign out_tdata  = {1'b0, cmp_val_out_r, duty_out_r, state_out_r};

endmodule

// ----- src/ftc_cfg_regs.sv -----
module ftc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output ftc_pkg::cfg_t      cfg
);

  logic [31:0] fan_on_time_r;
  logic [31:0] cooldown_time_r;
  logic [6:0]  default_pct_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_on_time_r   <= ftc_pkg::FAN_ON_TIME_RST;
      cooldown_time_r <= ftc_pkg::COOLDOWN_TIME_RST;
      default_pct_r   <= ftc_pkg::DEFAULT_PCT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ftc_pkg::REG_FAN_ON_TIME:   fan_on_time_r   <= cfg_pwdata;
        ftc_pkg::REG_COOLDOWN_TIME: cooldown_time_r <= cfg_pwdata;
        ftc_pkg::REG_DEFAULT_PCT:   default_pct_r   <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ftc_pkg::REG_FAN_ON_TIME:   cfg_prdata = fan_on_time_r;
      ftc_pkg::REG_COOLDOWN_TIME: cfg_prdata = cooldown_time_r;
      ftc_pkg::REG_DEFAULT_PCT:   cfg_prdata = {25'd0, default_pct_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.on_limit_ms = fan_on_time_r;
  assign cfg.cool_len_ms = cooldown_time_r;

endmodule

// ----- src/ftc_duty.sv -----
module ftc_duty (
  input  logic signed [15:0] temperature,
  input  logic signed [15:0] setpoint,
  output logic [7:0]         percent
);

  logic signed [16:0] diff;
  logic [15:0]        d;
  logic [18:0]        d_x5;
  logic [16:0]        raw;

  // only used while temperature > setpoint, so diff fits 16 bits unsigned
  assign diff = {temperature[15], temperature} - {setpoint[15], setpoint};
  assign d    = diff[15:0];
  assign d_x5 = {1'b0, d, 2'b00} + {3'b000, d};
  assign raw  = d_x5[18:2];

  always_comb begin
    if (raw < {9'd0, ftc_pkg::PCT_MIN}) begin
      percent = ftc_pkg::PCT_MIN;
    end else if (raw > {9'd0, ftc_pkg::PCT_MAX}) begin
      percent = ftc_pkg::PCT_MAX;
    end else begin
      percent = raw[7:0];
    end
  end

endmodule

// ----- src/ftc_step.sv -----
module ftc_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ftc_pkg::cfg_t      cfg,
  input  logic               mode,
  input  logic [31:0]        now_ms,
  input  logic signed [15:0] temperature,
  input  logic signed [15:0] setpoint,
  input  logic [7:0]         new_percent,
  output ftc_pkg::state_t    ctrl_state,
  output logic [7:0]         duty_percent,
  output logic               compare_write,
  output logic [12:0]        compare_value
);

  ftc_pkg::state_t state_r, state_nxt;
  logic [31:0]     phase_start_r, phase_start_nxt;
  logic [7:0]      pct_r, pct_nxt;

  logic [7:0]  calc_pct;
  logic [31:0] elapsed;
  logic        temp_above;
  logic        cmp_use;
  logic [7:0]  cmp_src;
  logic [29:0] cmp_prod;

  ftc_duty u_duty (
    .temperature (temperature),
    .setpoint    (setpoint),
    .percent     (calc_pct)
  );

  assign elapsed    = now_ms - phase_start_r;
  assign temp_above = temperature > setpoint;

  always_comb begin
    state_nxt       = state_r;
    phase_start_nxt = phase_start_r;
    pct_nxt         = pct_r;
    compare_write   = 1'b0;
    cmp_use         = 1'b0;
    if (mode) begin
      pct_nxt = new_percent;
      if (state_r == ftc_pkg::ST_FAN_ON) begin
        compare_write = 1'b1;
        cmp_use       = 1'b1;
      end
    end else begin
      case (state_r)
        ftc_pkg::ST_FAN_ON: begin
          compare_write = 1'b1;
          if (!temp_above) begin
            state_nxt = ftc_pkg::ST_IDLE;
          end else if (elapsed >= cfg.on_limit_ms) begin
            state_nxt       = ftc_pkg::ST_COOLDOWN;
            phase_start_nxt = now_ms;
          end else begin
            pct_nxt = calc_pct;
            cmp_use = 1'b1;
          end
        end
        ftc_pkg::ST_COOLDOWN: begin
          if (elapsed >= cfg.cool_len_ms) state_nxt = ftc_pkg::ST_IDLE;
        end
        default: begin
          // idle, and the unused code treated as idle
          state_nxt = ftc_pkg::ST_IDLE;
          if (temp_above) begin
            state_nxt       = ftc_pkg::ST_FAN_ON;
            phase_start_nxt = now_ms;
            pct_nxt         = calc_pct;
            compare_write   = 1'b1;
            cmp_use         = 1'b1;
          end
        end
      endcase
    end
  end

  // cmp_src is either the set value or the computed duty
  assign cmp_src  = mode ? new_percent : calc_pct;
  assign cmp_prod = {22'd0, cmp_src} * {8'd0, ftc_pkg::CMP_RECIP};
  assign compare_value = cmp_use ? cmp_prod[ftc_pkg::CMP_SHIFT +: 13] : 13'd0;

  assign ctrl_state   = state_nxt;
  assign duty_percent = pct_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ftc_pkg::ST_IDLE;
      phase_start_r <= 32'd0;
      pct_r         <= {1'b0, ftc_pkg::DEFAULT_PCT_RST};
    end else if (fire) begin
      state_r       <= state_nxt;
      phase_start_r <= phase_start_nxt;
      pct_r         <= pct_nxt;
    end
  end

endmodule

// ----- src/ftc_checker.sv -----
`include "fan_thermostat_controller_defines.svh"

module ftc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  logic [1:0]  out_state;
  logic [12:0] out_cmp;
  logic        cmp_nz;
  logic        stalled;

  assign out_state = out_tdata[1:0];
  assign out_cmp   = out_tdata[22:10];
  assign cmp_nz    = out_tvalid && out_tuser && (out_cmp != 13'd0);
  assign stalled   = out_tvalid && !out_tready;

  // no compare write means the value field is clear
  `FTC_ASSERT_IMP(a_cmp_zero_no_wr, clk, rst_n, out_tvalid && !out_tuser, out_cmp == 13'd0)

  // a nonzero compare is only ever written while the reported state is fan on
  `FTC_ASSERT_IMP(a_cmp_fan_on, clk, rst_n, cmp_nz, out_state == ftc_pkg::ST_FAN_ON)

  // a sink that is ready never throttles the source
  `FTC_ASSERT_IMP(a_ready_flow, clk, rst_n, out_tready, in_tready)

  `FTC_ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_tvalid && $stable({out_tuser, out_tdata}))

endmodule

bind fan_thermostat_controller ftc_checker u_ftc_checker (.*);
